FILE: hw/rtl/sbps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbps_pkg
// Shared constants and controller/datapath interface types for the slot
// buffer with ring insert and priority select.
// ----------------------------------------------------------------------------
package sbps_pkg;

  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;
  localparam int SLOT_IDX_W = 3;
  localparam int WAIT_W     = 32;
  localparam int SRC_W      = 8;
  localparam int REQ_W      = 16;
  localparam int CFG_REG_W  = 4;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_EVICT  = 2'd1;
  localparam logic [OP_W-1:0] OP_TAKE   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic load;       // capture a new request
    logic ins_step;   // test one slot at the cursor for insert
    logic rd_cursor;  // read the slot at the cursor
    logic rd_scan;    // read the slot at the scan index
    logic cap_force;  // capture the read slot if it is valid
    logic cap_cmp;    // capture the read slot if it beats the best so far
    logic remove;     // free the selected slot
    logic out_load;   // load the result register
  } sbps_cmd_t;

  typedef struct packed {
    logic ins_hit;
    logic scan_last;
    logic out_busy;
  } sbps_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/sbps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbps_ctrl
// Sequencer for insert, evict and take requests; drives datapath commands.
// ----------------------------------------------------------------------------
module sbps_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [sbps_pkg::OP_W-1:0]    in_operation,
  input  sbps_pkg::sbps_stat_t         stat,
  output sbps_pkg::sbps_cmd_t          cmd,
  output logic                         idle
);
  import sbps_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_INS  = 8'b0000_0010,
    S_EVR  = 8'b0000_0100,
    S_EVC  = 8'b0000_1000,
    S_TAKE = 8'b0001_0000,
    S_TCMP = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    idle      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_operation)
            OP_INSERT: state_nxt = S_INS;
            OP_EVICT:  state_nxt = S_EVR;
            OP_TAKE:   state_nxt = S_TAKE;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (stat.ins_hit || stat.scan_last) state_nxt = S_FIN;
      end
      S_EVR: begin
        cmd.rd_cursor = 1'b1;
        state_nxt     = S_EVC;
      end
      S_EVC: begin
        cmd.cap_force = 1'b1;
        state_nxt     = S_FIN;
      end
      S_TAKE: begin
        // Reads and compares overlap: each cycle judges the slot read last cycle.
        cmd.rd_scan = 1'b1;
        cmd.cap_cmp = 1'b1;
        if (stat.scan_last) state_nxt = S_TCMP;
      end
      S_TCMP: begin
        cmd.cap_cmp = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        cmd.remove = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/sbps_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbps_datapath
// Slot memory, valid bits, ring cursor, scan comparator and result register.
// ----------------------------------------------------------------------------
module sbps_datapath #(
  parameter int DEPTH      = 8,
  parameter int TIME_WIDTH = 32,
  parameter int CFG_W      = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sbps_pkg::sbps_cmd_t                cmd,
  output sbps_pkg::sbps_stat_t               stat,
  input  logic [CFG_W-1:0]                   cfg_slots,
  input  logic [sbps_pkg::OP_W-1:0]          in_operation,
  input  logic [sbps_pkg::WAIT_W-1:0]        in_wait_time,
  input  logic [sbps_pkg::SRC_W-1:0]         in_source_num,
  input  logic [sbps_pkg::REQ_W-1:0]         in_request_num,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [sbps_pkg::STAT_W-1:0]        out_status,
  output logic [sbps_pkg::SLOT_IDX_W-1:0]    out_slot_index,
  output logic [sbps_pkg::WAIT_W-1:0]        out_wait_time,
  output logic [sbps_pkg::SRC_W-1:0]         out_source_num,
  output logic [sbps_pkg::REQ_W-1:0]         out_request_num,
  output logic                               out_any_free,
  output logic                               out_all_empty
);
  import sbps_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [TIME_WIDTH-1:0] wt;
    logic [SRC_W-1:0]      src;
    logic [REQ_W-1:0]      req;
  } slot_t;

  slot_t mem [DEPTH];
  slot_t in_r, rd_data_r, best_r;

  logic [OP_W-1:0]  op_r;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0] cursor_r, cursor_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic             out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0] n;
  logic [DEPTH-1:0] active_mask;
  logic [IDX_W-1:0] cur_adv, rd_addr;
  logic             cur_free, rd_en, wr_en, better, capture, removed;

  // Active slot count; out-of-range settings clamp to 1 or DEPTH.
  always_comb begin
    if (cfg_slots == '0) begin
      n = CNT_W'(1);
    end else if (cfg_slots > CFG_W'(DEPTH)) begin
      n = CNT_W'(DEPTH);
    end else begin
      n = CNT_W'(cfg_slots);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      active_mask[i] = (CNT_W'(i) < n);
    end
  end

  assign cur_adv  = ((CNT_W'(cursor_r) + CNT_W'(1)) >= n) ? '0 : cursor_r + IDX_W'(1);
  assign cur_free = ~valid_r[cursor_r];
  assign rd_en    = cmd.rd_cursor | cmd.rd_scan;
  assign rd_addr  = cmd.rd_cursor ? cursor_r : step_r[IDX_W-1:0];
  assign wr_en    = cmd.ins_step & cur_free;

  // Smaller wait wins, then smaller source, then larger request number.
  assign better = (rd_data_r.wt < best_r.wt) ||
                  ((rd_data_r.wt == best_r.wt) && (rd_data_r.src < best_r.src)) ||
                  ((rd_data_r.wt == best_r.wt) && (rd_data_r.src == best_r.src) &&
                   (rd_data_r.req > best_r.req));

  assign capture = rd_ok_r & (cmd.cap_force | (cmd.cap_cmp & (~found_r | better)));
  assign removed = found_r & (op_r != OP_INSERT);

  assign stat.ins_hit   = cur_free;
  assign stat.scan_last = (step_r == (n - CNT_W'(1)));
  assign stat.out_busy  = out_valid_r & out_stall;

  always_comb begin
    valid_nxt     = valid_r;
    cursor_nxt    = cursor_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    rd_ok_nxt     = rd_en & valid_r[rd_addr];
    out_valid_nxt = out_valid_r;

    if (cmd.load) begin
      found_nxt = 1'b0;
      step_nxt  = '0;
      if (((in_operation == OP_INSERT) || (in_operation == OP_EVICT)) &&
          (CNT_W'(cursor_r) >= n)) begin
        cursor_nxt = '0;
      end
    end

    if (cmd.ins_step) begin
      cursor_nxt = cur_adv;
      if (cur_free) begin
        valid_nxt[cursor_r] = 1'b1;
        found_nxt           = 1'b1;
        best_idx_nxt        = cursor_r;
      end else begin
        step_nxt = step_r + CNT_W'(1);
      end
    end

    if (cmd.rd_scan) begin
      step_nxt = step_r + CNT_W'(1);
    end

    if (capture) begin
      found_nxt    = 1'b1;
      best_idx_nxt = rd_idx_r;
    end

    if (cmd.remove && removed) begin
      valid_nxt[best_idx_r] = 1'b0;
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cursor_r    <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      best_idx_r  <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      cursor_r    <= cursor_nxt;
      step_r      <= step_nxt;
      found_r     <= found_nxt;
      best_idx_r  <= best_idx_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cursor_r] <= in_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      in_r   <= '{wt: TIME_WIDTH'(in_wait_time), src: in_source_num, req: in_request_num};
    end
    rd_idx_r <= rd_addr;
    if (capture) begin
      best_r <= rd_data_r;
    end
    if (cmd.out_load) begin
      out_status      <= found_r ? ST_DONE : ((op_r == OP_INSERT) ? ST_FULL : ST_EMPTY);
      out_slot_index  <= found_r ? SLOT_IDX_W'(best_idx_r) : '0;
      out_wait_time   <= removed ? WAIT_W'(best_r.wt) : '0;
      out_source_num  <= removed ? best_r.src : '0;
      out_request_num <= removed ? best_r.req : '0;
      out_any_free    <= |(~valid_r & active_mask);
      out_all_empty   <= ~|(valid_r & active_mask);
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: hw/rtl/slot_buffer_priority_select_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slot_buffer_priority_select_core
// Buffer of request slots with ring-cursor insert, evict at the cursor and
// a take that removes the best request by wait time, source and number.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall; each gives exactly one result on
//   out_valid/out_stall. One request is in work at a time; in_stall is high
//   while it is, and the next request may enter while a result still waits.
//   With n active slots, an insert tests slots from the cursor on until one
//   is free or all n have been tried; an evict reads the slot at the cursor;
//   a take scans all n slots; an unknown operation goes straight to its result.
//   The next request is accepted in the cycle after the result is registered;
//   insert and take walk one slot per cycle over the valid bits and the slot
//   memory read port with its single comparator.
//   A stalled result holds its output register; the sequencer waits before
//   loading the next result until the previous one is taken.
//   Reset empties all slots, puts the cursor at slot 0 and sets the slot
//   count register (APB address 0) to DEPTH; no clearing pass is needed.
// ----------------------------------------------------------------------------
module slot_buffer_priority_select_core #(
  parameter int DEPTH      = 8,
  parameter int TIME_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sbps_pkg::OP_W-1:0]           in_operation,
  input  logic [sbps_pkg::WAIT_W-1:0]         in_wait_time,
  input  logic [sbps_pkg::SRC_W-1:0]          in_source_num,
  input  logic [sbps_pkg::REQ_W-1:0]          in_request_num,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [sbps_pkg::STAT_W-1:0]         out_status,
  output logic [sbps_pkg::SLOT_IDX_W-1:0]     out_slot_index,
  output logic [sbps_pkg::WAIT_W-1:0]         out_wait_time,
  output logic [sbps_pkg::SRC_W-1:0]          out_source_num,
  output logic [sbps_pkg::REQ_W-1:0]          out_request_num,
  output logic                                out_any_free,
  output logic                                out_all_empty,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sbps_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [sbps_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sbps_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import sbps_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CFG_W = (CNT_W > CFG_REG_W) ? CNT_W : CFG_REG_W;

  logic [CFG_W-1:0] cfg_slots_r;
  logic             reg_sel;
  sbps_cmd_t        cmd;
  sbps_stat_t       stat;
  logic             idle;

  // Addresses with paddr[2] low (0 to 3) all map to the slot count register; 4 to 7 read as zero.
  assign reg_sel = (paddr[APB_ADDR_W-1] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(cfg_slots_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_slots_r <= CFG_W'(DEPTH);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      cfg_slots_r <= CFG_W'(pwdata[CFG_REG_W-1:0]);
    end
  end

  assign in_stall = ~idle;

  sbps_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .idle         (idle)
  );

  sbps_datapath #(
    .DEPTH      (DEPTH),
    .TIME_WIDTH (TIME_WIDTH),
    .CFG_W      (CFG_W)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_slots       (cfg_slots_r),
    .in_operation    (in_operation),
    .in_wait_time    (in_wait_time),
    .in_source_num   (in_source_num),
    .in_request_num  (in_request_num),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_wait_time   (out_wait_time),
    .out_source_num  (out_source_num),
    .out_request_num (out_request_num),
    .out_any_free    (out_any_free),
    .out_all_empty   (out_all_empty)
  );

endmodule
`default_nettype wire
